### hw/rtl/rwsp_pkg.sv
// Shared constants, types and helpers of the ratio-weighted server picker.
package rwsp_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int RATIO_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int NUM_WORDS   = 4;
  localparam int WORD_W      = 64;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int ROUND_W     = 22;
  localparam int SUM_W       = 21;
  localparam int HEAD_W      = 21;
  localparam int PROD_W      = 2 * ROUND_W;
  localparam int CFG_IDX_W   = 3;

  localparam logic [FIELD_W-1:0] RATIO_MASK = FIELD_W'((1 << RATIO_BITS) - 1);

  localparam logic [CFG_IDX_W-1:0] REG_RATIO_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 3'd4;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] ratio_words_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEL,
    ST_CS,
    ST_C0,
    ST_CP,
    ST_CL,
    ST_MR,
    ST_CMP,
    ST_COMMIT
  } state_t;

  // Effective ratio of server k: masked field, zero taken as one.
  function automatic logic [RATIO_BITS-1:0] ratio_field(input ratio_words_t words,
                                                        input logic [IDX_W-1:0] k);
    logic [WORD_W-1:0]  w;
    logic [FIELD_W-1:0] f;
    w = words[k[3:2]] >> {k[1:0], 4'b0000};
    f = w[FIELD_W-1:0] & RATIO_MASK;
    if (f == '0) begin
      f = FIELD_W'(1);
    end
    return f[RATIO_BITS-1:0];
  endfunction

  // Saturate the server count to 1..MAX_SERVERS.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(MAX_SERVERS)) begin
      r = CNT_W'(MAX_SERVERS);
    end
    return r;
  endfunction

endpackage

### hw/rtl/rwsp_if.sv
// Valid/ready channel interfaces for requests, picks and configuration writes.
interface rwsp_req_if;
  logic valid;
  logic ready;
  logic request;
  modport source (output valid, output request, input ready);
  modport sink (input valid, input request, output ready);
endinterface

interface rwsp_pick_if;
  logic                      valid;
  logic                      ready;
  logic [rwsp_pkg::IDX_W-1:0] server_index;
  modport source (output valid, output server_index, input ready);
  modport sink (input valid, input server_index, output ready);
endinterface

interface rwsp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rwsp_pkg::CFG_IDX_W-1:0] index;
  logic [rwsp_pkg::WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/ratio_weighted_server_picker_core.sv
// Ratio-weighted server picker: iterative weighted round robin with a shared multiplier.
// After reset and after every write to a listed register the block loads the credit
// memory from the ratios and takes no request meanwhile; configuration writes are always
// taken. A request with the request bit clear is taken and gives no result. A pick
// accepts the request, then per candidate reads its credit (select, credit check) and
// skips it if exhausted; server 0 goes straight to commit, any other first gets a
// head/tail test (read server 0, the one before it and the last server, form both
// products, compare). The commit waits while the previous result is held. The credit
// memory with one registered read a cycle and the one 22x22 multiplier set these steps.
// The result sits in an output register, so the next request is taken while it waits.
module ratio_weighted_server_picker_core (
  input  logic              clk,
  input  logic              rst,
  rwsp_req_if.sink          req,
  rwsp_pick_if.source       pick,
  rwsp_cfg_if.sink          cfg
);

  localparam int RB = rwsp_pkg::RATIO_BITS;

  rwsp_pkg::state_t state, state_next;

  rwsp_pkg::ratio_words_t          words;
  logic [rwsp_pkg::CNT_W-1:0]      used_n;
  logic [RB-1:0]                   eff_last;

  logic [RB-1:0]                   credit_mem [rwsp_pkg::MAX_SERVERS];
  logic [RB-1:0]                   rd_data;
  logic [rwsp_pkg::IDX_W-1:0]      rd_addr;
  logic                            wr_en;
  logic [rwsp_pkg::IDX_W-1:0]      wr_addr;
  logic [RB-1:0]                   wr_data;

  logic [rwsp_pkg::IDX_W-1:0]      init_k;
  logic [rwsp_pkg::IDX_W-1:0]      cur;
  logic [rwsp_pkg::IDX_W-1:0]      s;
  logic [rwsp_pkg::ROUND_W-1:0]    round;
  logic [rwsp_pkg::SUM_W-1:0]      left;
  logic [rwsp_pkg::SUM_W-1:0]      full;
  logic [rwsp_pkg::CNT_W-1:0]      rearm;
  logic [RB-1:0]                   cs;
  logic [RB-1:0]                   c0;
  logic [rwsp_pkg::HEAD_W-1:0]     head;
  logic [rwsp_pkg::PROD_W-1:0]     prod;
  logic                            out_valid;
  logic [rwsp_pkg::IDX_W-1:0]      out_idx;

  logic [rwsp_pkg::ROUND_W-1:0]    mul_a;
  logic [rwsp_pkg::ROUND_W-1:0]    mul_b;
  logic                            cfg_hit;
  logic                            commit_go;
  logic [rwsp_pkg::IDX_W-1:0]      s_sel;
  logic [RB-1:0]                   init_val;
  logic [RB-1:0]                   ratio_s;
  logic [RB-1:0]                   last_val;
  logic [rwsp_pkg::CNT_W-1:0]      cur_inc;
  logic                            cur_wrap;
  logic [rwsp_pkg::SUM_W-1:0]      full_sum;
  logic [rwsp_pkg::SUM_W-1:0]      left_dec;
  logic                            rd_zero;
  logic                            pass;

  assign cfg.ready    = 1'b1;
  assign cfg_hit      = cfg.valid && (cfg.index <= rwsp_pkg::REG_SERVER_COUNT);
  assign pick.valid   = out_valid;
  assign pick.server_index = out_idx;
  assign commit_go    = (state == rwsp_pkg::ST_COMMIT) && (!out_valid || pick.ready);

  assign s_sel    = ({1'b0, cur} >= used_n) ? '0 : cur;
  assign init_val = ({1'b0, init_k} < used_n) ? rwsp_pkg::ratio_field(words, init_k) : '0;
  assign ratio_s  = rwsp_pkg::ratio_field(words, s);
  assign rd_zero  = (rd_data == '0);
  assign last_val = rd_zero ? eff_last : rd_data;
  assign cur_inc  = {1'b0, cur} + rwsp_pkg::CNT_W'(1);
  assign cur_wrap = (cur_inc >= used_n);
  assign full_sum = full + rwsp_pkg::SUM_W'(init_val);
  assign left_dec = left - rwsp_pkg::SUM_W'(1);
  assign pass     = prod > rwsp_pkg::PROD_W'(head);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rwsp_pkg::ST_INIT: begin
        if (init_k == rwsp_pkg::IDX_W'(rwsp_pkg::MAX_SERVERS - 1)) begin
          state_next = rwsp_pkg::ST_IDLE;
        end
      end
      rwsp_pkg::ST_IDLE: begin
        if (req.valid && req.request) begin
          state_next = rwsp_pkg::ST_SEL;
        end
      end
      rwsp_pkg::ST_SEL: state_next = rwsp_pkg::ST_CS;
      rwsp_pkg::ST_CS: begin
        if (rd_zero && (rearm != {1'b0, s})) begin
          state_next = rwsp_pkg::ST_SEL;
        end else if (s == '0) begin
          state_next = rwsp_pkg::ST_COMMIT;
        end else begin
          state_next = rwsp_pkg::ST_C0;
        end
      end
      rwsp_pkg::ST_C0:  state_next = rwsp_pkg::ST_CP;
      rwsp_pkg::ST_CP:  state_next = rwsp_pkg::ST_CL;
      rwsp_pkg::ST_CL:  state_next = rwsp_pkg::ST_MR;
      rwsp_pkg::ST_MR:  state_next = rwsp_pkg::ST_CMP;
      rwsp_pkg::ST_CMP: state_next = pass ? rwsp_pkg::ST_COMMIT : rwsp_pkg::ST_SEL;
      rwsp_pkg::ST_COMMIT: begin
        if (commit_go) begin
          state_next = rwsp_pkg::ST_IDLE;
        end
      end
      default: state_next = rwsp_pkg::ST_INIT;
    endcase
    if (cfg_hit) begin
      state_next = rwsp_pkg::ST_INIT;
    end
  end

  // Outputs: memory port, multiplier operands, request ready.
  always_comb begin
    req.ready = 1'b0;
    rd_addr   = s;
    wr_en     = 1'b0;
    wr_addr   = s;
    wr_data   = cs;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      rwsp_pkg::ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_k;
        wr_data = init_val;
      end
      rwsp_pkg::ST_IDLE: req.ready = 1'b1;
      rwsp_pkg::ST_SEL:  rd_addr = s_sel;
      rwsp_pkg::ST_CS: begin
        rd_addr = '0;
        if (rd_zero && (rearm == {1'b0, s})) begin
          wr_en   = 1'b1;
          wr_data = ratio_s;
        end
      end
      rwsp_pkg::ST_C0: rd_addr = s - rwsp_pkg::IDX_W'(1);
      rwsp_pkg::ST_CP: begin
        rd_addr = rwsp_pkg::IDX_W'(used_n - rwsp_pkg::CNT_W'(1));
        mul_a   = rwsp_pkg::ROUND_W'({1'b0, c0} + {1'b0, rd_data});
        mul_b   = rwsp_pkg::ROUND_W'(s);
      end
      rwsp_pkg::ST_CL: begin
        mul_a = rwsp_pkg::ROUND_W'({1'b0, cs} + {1'b0, last_val});
        mul_b = rwsp_pkg::ROUND_W'(used_n - {1'b0, s});
      end
      rwsp_pkg::ST_MR: begin
        mul_a = prod[rwsp_pkg::ROUND_W-1:0];
        mul_b = round;
      end
      rwsp_pkg::ST_COMMIT: begin
        wr_en   = commit_go;
        wr_data = cs - RB'(1);
      end
      default: ;
    endcase
  end

  // Credit memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      credit_mem[wr_addr] <= wr_data;
    end
    rd_data <= credit_mem[rd_addr];
  end

  // Shared multiplier, product registered.
  always_ff @(posedge clk) begin
    prod <= rwsp_pkg::PROD_W'(mul_a) * rwsp_pkg::PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rwsp_pkg::ST_INIT;
      words     <= rwsp_pkg::ratio_words_t'(rwsp_pkg::WORD_W'(1));
      used_n    <= rwsp_pkg::CNT_W'(1);
      init_k    <= '0;
      full      <= '0;
      left      <= '0;
      cur       <= '0;
      round     <= rwsp_pkg::ROUND_W'(1);
      rearm     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pick.ready && !commit_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        rwsp_pkg::ST_INIT: begin
          if (!cfg_hit) begin
            init_k <= init_k + rwsp_pkg::IDX_W'(1);
            full   <= full_sum;
          end
          if ({1'b0, init_k} == used_n - rwsp_pkg::CNT_W'(1)) begin
            eff_last <= init_val;
          end
          if (init_k == rwsp_pkg::IDX_W'(rwsp_pkg::MAX_SERVERS - 1)) begin
            left  <= full_sum;
            cur   <= '0;
            round <= rwsp_pkg::ROUND_W'(1);
            rearm <= used_n;
          end
        end
        rwsp_pkg::ST_SEL: begin
          s   <= s_sel;
          cur <= s_sel;
        end
        rwsp_pkg::ST_CS: begin
          if (rd_zero && (rearm != {1'b0, s})) begin
            // skip an exhausted server
            cur <= cur_wrap ? '0 : cur_inc[rwsp_pkg::IDX_W-1:0];
            if (cur_wrap) begin
              round <= rwsp_pkg::ROUND_W'(1);
            end
          end else if (rd_zero) begin
            cs    <= ratio_s;
            rearm <= rearm + rwsp_pkg::CNT_W'(1);
          end else begin
            cs <= rd_data;
          end
        end
        rwsp_pkg::ST_C0: c0 <= rd_data;
        rwsp_pkg::ST_CL: head <= prod[rwsp_pkg::HEAD_W-1:0];
        rwsp_pkg::ST_CMP: begin
          if (!pass) begin
            cur   <= '0;
            round <= round + rwsp_pkg::ROUND_W'(1);
          end
        end
        rwsp_pkg::ST_COMMIT: begin
          if (commit_go) begin
            out_valid <= 1'b1;
            out_idx   <= s;
            if (left_dec == '0) begin
              cur   <= '0;
              round <= rwsp_pkg::ROUND_W'(1);
              left  <= full;
              rearm <= '0;
            end else begin
              left <= left_dec;
              cur  <= cur_wrap ? '0 : cur_inc[rwsp_pkg::IDX_W-1:0];
              if (cur_wrap) begin
                round <= rwsp_pkg::ROUND_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
      // any write to a mapped register restarts the credit load
      if (cfg_hit) begin
        init_k <= '0;
        full   <= '0;
        case (cfg.index)
          rwsp_pkg::REG_RATIO_WORD_0: words[0] <= cfg.data;
          rwsp_pkg::REG_RATIO_WORD_1: words[1] <= cfg.data;
          rwsp_pkg::REG_RATIO_WORD_2: words[2] <= cfg.data;
          rwsp_pkg::REG_RATIO_WORD_3: words[3] <= cfg.data;
          rwsp_pkg::REG_SERVER_COUNT:
            used_n <= rwsp_pkg::clamp_count(cfg.data[rwsp_pkg::CNT_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == rwsp_pkg::ST_IDLE) |-> ({1'b0, cur} < used_n))
    else $error("current server beyond server count");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != rwsp_pkg::ST_INIT) |-> (left != '0))
    else $error("credit total reached zero without restart");

  a_round_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != rwsp_pkg::ST_INIT) |-> (round != '0))
    else $error("round number wrapped");

  a_commit_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == rwsp_pkg::ST_COMMIT) && out_valid && !pick.ready && !cfg_hit)
      |=> (state == rwsp_pkg::ST_COMMIT))
    else $error("pick committed over an untaken result");

endmodule

### dv/tb.sv
// Self-checking testbench for the ratio-weighted server picker core.
module tb;

  localparam int HOLD_LEN       = 300;   // long sink hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on any channel
  localparam int SETTLE_CYCLES  = 40;    // drain time before a write and at the end
  localparam int RANDOM_PICKS   = 1225;
  localparam int MAX_PRINTED    = 100;

  // Unmapped register indexes: the block must take the write and keep its state.
  localparam logic [rwsp_pkg::CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [rwsp_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic clk;
  logic rst;

  rwsp_req_if  req_ch ();
  rwsp_pick_if pick_ch ();
  rwsp_cfg_if  cfg_ch ();

  ratio_weighted_server_picker_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .pick (pick_ch),
    .cfg  (cfg_ch)
  );

  // Picker state as seen by the scoreboard.
  logic [rwsp_pkg::WORD_W-1:0]  pm_words [rwsp_pkg::NUM_WORDS];
  logic [rwsp_pkg::CNT_W-1:0]   pm_count_reg;
  logic [rwsp_pkg::CNT_W-1:0]   pm_n;
  logic [rwsp_pkg::FIELD_W-1:0] pm_ratio [rwsp_pkg::MAX_SERVERS];
  logic [rwsp_pkg::FIELD_W-1:0] pm_credit [rwsp_pkg::MAX_SERVERS];
  logic [rwsp_pkg::CNT_W-1:0]   pm_cur;
  logic [rwsp_pkg::ROUND_W-1:0] pm_round;
  logic [rwsp_pkg::SUM_W-1:0]   pm_left;
  logic [rwsp_pkg::SUM_W-1:0]   pm_full;
  logic [rwsp_pkg::CNT_W-1:0]   pm_rearm;

  logic [rwsp_pkg::IDX_W-1:0] picks_due [$];
  bit                         pending_reqs [$];
  logic [rwsp_pkg::IDX_W-1:0] due_idx;

  int errors = 0;
  int src_idle_pct = 10;
  int snk_idle_pct = 10;
  int src_gap;
  int snk_gap;
  int hold_cnt;
  bit long_hold_go = 1'b0;
  int stall_count;

  wire long_holding = long_hold_go && (hold_cnt < HOLD_LEN);
  wire any_transfer = (req_ch.valid && req_ch.ready) || (pick_ch.valid && pick_ch.ready) ||
                      (cfg_ch.valid && cfg_ch.ready);

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  // Load credits and totals from the ratio words and the server count.
  function automatic void reload_credits();
    logic [rwsp_pkg::WORD_W-1:0]  w;
    logic [rwsp_pkg::FIELD_W-1:0] f;
    if (pm_count_reg == '0) begin
      pm_n = rwsp_pkg::CNT_W'(1);
    end else if (pm_count_reg > rwsp_pkg::MAX_SERVERS) begin
      pm_n = rwsp_pkg::CNT_W'(rwsp_pkg::MAX_SERVERS);
    end else begin
      pm_n = pm_count_reg;
    end
    pm_full = '0;
    for (int k = 0; k < rwsp_pkg::MAX_SERVERS; k++) begin
      w = pm_words[k / 4] >> (16 * (k % 4));
      f = w[rwsp_pkg::FIELD_W-1:0] & rwsp_pkg::RATIO_MASK;
      if (f == '0) begin
        f = rwsp_pkg::FIELD_W'(1);
      end
      pm_ratio[k]  = (k < pm_n) ? f : '0;
      pm_credit[k] = pm_ratio[k];
      pm_full      = pm_full + rwsp_pkg::SUM_W'(pm_ratio[k]);
    end
    pm_left  = pm_full;
    pm_cur   = '0;
    pm_round = rwsp_pkg::ROUND_W'(1);
    pm_rearm = pm_n;
  endfunction

  function automatic void reset_picker_state();
    pm_words[0]  = rwsp_pkg::WORD_W'(1);
    pm_words[1]  = '0;
    pm_words[2]  = '0;
    pm_words[3]  = '0;
    pm_count_reg = rwsp_pkg::CNT_W'(1);
    reload_credits();
  endfunction

  function automatic void apply_reg_write(input logic [rwsp_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [rwsp_pkg::WORD_W-1:0] data);
    bit mapped;
    mapped = 1'b1;
    case (idx)
      rwsp_pkg::REG_RATIO_WORD_0: pm_words[0] = data;
      rwsp_pkg::REG_RATIO_WORD_1: pm_words[1] = data;
      rwsp_pkg::REG_RATIO_WORD_2: pm_words[2] = data;
      rwsp_pkg::REG_RATIO_WORD_3: pm_words[3] = data;
      rwsp_pkg::REG_SERVER_COUNT: pm_count_reg = data[rwsp_pkg::CNT_W-1:0];
      default: mapped = 1'b0;
    endcase
    if (mapped) begin
      reload_credits();
    end
  endfunction

  // Proportional head/tail test; server 0 always passes.
  function automatic bit head_tail_ok(input logic [rwsp_pkg::CNT_W-1:0] s);
    logic [rwsp_pkg::FIELD_W-1:0] last;
    logic [63:0]                  head;
    logic [63:0]                  tail;
    if (s == '0) begin
      return 1'b1;
    end
    last = pm_credit[pm_n - 1];
    if (last == '0) begin
      last = pm_ratio[pm_n - 1];
    end
    head = (64'(pm_credit[0]) + 64'(pm_credit[s - 1])) * 64'(s);
    tail = (64'(pm_credit[s]) + 64'(last)) * (64'(pm_n) - 64'(s));
    return (tail * 64'(pm_round)) > head;
  endfunction

  // Advance the picker by one request and return the chosen server.
  function automatic logic [rwsp_pkg::IDX_W-1:0] next_server();
    logic [rwsp_pkg::CNT_W-1:0] s;
    logic [rwsp_pkg::IDX_W-1:0] chosen;
    bit                         done;
    done   = 1'b0;
    chosen = '0;
    while (!done) begin
      s = {1'b0, pm_cur[rwsp_pkg::IDX_W-1:0]};
      if (s >= pm_n) begin
        pm_cur = '0;
        s      = '0;
      end
      if (pm_credit[s] == '0 && pm_rearm != s) begin
        // skip an exhausted server
        pm_cur = pm_cur + 1'b1;
        if (pm_cur >= pm_n) begin
          pm_cur   = '0;
          pm_round = rwsp_pkg::ROUND_W'(1);
        end
      end else begin
        if (pm_credit[s] == '0) begin
          pm_credit[s] = pm_ratio[s];
          pm_rearm     = pm_rearm + 1'b1;
        end
        if (head_tail_ok(s)) begin
          pm_credit[s] = pm_credit[s] - 1'b1;
          pm_left      = pm_left - 1'b1;
          if (pm_left == '0) begin
            pm_cur   = '0;
            pm_round = rwsp_pkg::ROUND_W'(1);
            pm_left  = pm_full;
            pm_rearm = '0;
          end else begin
            pm_cur = pm_cur + 1'b1;
            if (pm_cur >= pm_n) begin
              pm_cur   = '0;
              pm_round = rwsp_pkg::ROUND_W'(1);
            end
          end
          chosen = s[rwsp_pkg::IDX_W-1:0];
          done   = 1'b1;
        end else begin
          pm_cur   = '0;
          pm_round = pm_round + 1'b1;
        end
      end
    end
    return chosen;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request driver: hold the item until transfer, idle in short bursts.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.request <= 1'b0;
      src_gap        <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (src_gap != 0) begin
        src_gap      <= src_gap - 1;
        req_ch.valid <= 1'b0;
      end else if ($urandom_range(0, 99) < src_idle_pct) begin
        src_gap      <= $urandom_range(0, 6);
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req_ch.valid   <= 1'b1;
        req_ch.request <= pending_reqs.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Long sink hold-off, counted here once started.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (long_hold_go && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Monitor: check picks, track register writes and requests, drive pick ready.
  always @(posedge clk) begin
    if (rst) begin
      pick_ch.ready <= 1'b0;
      snk_gap       <= 0;
      reset_picker_state();
    end else begin
      if (pick_ch.valid && pick_ch.ready) begin
        if (picks_due.size() == 0) begin
          report_mismatch($sformatf("unexpected pick of server %0d", pick_ch.server_index));
        end else begin
          due_idx = picks_due.pop_front();
          if (pick_ch.server_index !== due_idx) begin
            report_mismatch($sformatf("server_index %0d, expected %0d",
                                      pick_ch.server_index, due_idx));
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg_write(cfg_ch.index, cfg_ch.data);
      end
      if (req_ch.valid && req_ch.ready && req_ch.request) begin
        picks_due.push_back(next_server());
      end
      if (long_holding) begin
        pick_ch.ready <= 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap       <= snk_gap - 1;
        pick_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < snk_idle_pct) begin
        snk_gap       <= $urandom_range(0, 6);
        pick_ch.ready <= 1'b0;
      end else begin
        pick_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    stall_count = 0;
    while (stall_count < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || any_transfer) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Wait for every pick to come back, then let the block settle. Sample between edges
  // so the driver and monitor updates of the last edge are already visible.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || picks_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Present one write; valid stays high so writes can go back to back.
  task automatic write_reg(input logic [rwsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rwsp_pkg::WORD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input rwsp_pkg::ratio_words_t words,
                           input logic [rwsp_pkg::WORD_W-1:0] count_data,
                           input bit count_first);
    wait_idle();
    if (count_first) begin
      write_reg(rwsp_pkg::REG_SERVER_COUNT, count_data);
    end
    write_reg(rwsp_pkg::REG_RATIO_WORD_0, words[0]);
    write_reg(rwsp_pkg::REG_RATIO_WORD_1, words[1]);
    write_reg(rwsp_pkg::REG_RATIO_WORD_2, words[2]);
    write_reg(rwsp_pkg::REG_RATIO_WORD_3, words[3]);
    if (!count_first) begin
      write_reg(rwsp_pkg::REG_SERVER_COUNT, count_data);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Queue picks with an occasional ignored request in between.
  task automatic push_requests(input int picks);
    for (int i = 0; i < picks; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_reqs.push_back(1'b0);
      end
      pending_reqs.push_back(1'b1);
    end
  endtask

  function automatic void make_random_config(output rwsp_pkg::ratio_words_t words,
                                             output logic [rwsp_pkg::WORD_W-1:0] count_data);
    int vals [rwsp_pkg::MAX_SERVERS];
    int profile;
    int top;
    int tmp;
    int j;
    profile = $urandom_range(0, 9);
    case ($urandom_range(0, 4))
      0: top = 1;
      1: top = 2;
      2: top = 3;
      3: top = 7;
      default: top = 15;
    endcase
    if (profile >= 6 && profile < 8) begin
      top = 255;
    end else if (profile >= 8) begin
      top = 65535;
    end
    for (int k = 0; k < rwsp_pkg::MAX_SERVERS; k++) begin
      vals[k] = (profile == 8) ? $urandom_range(65000, 65535) : $urandom_range(1, top);
    end
    if ($urandom_range(0, 9) < 7) begin
      // sort descending, the intended use
      for (int k = 1; k < rwsp_pkg::MAX_SERVERS; k++) begin
        tmp = vals[k];
        j   = k - 1;
        while (j >= 0 && vals[j] < tmp) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = tmp;
      end
    end
    for (int k = 0; k < rwsp_pkg::MAX_SERVERS; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        vals[k] = 0;
      end
      words[k / 4][16 * (k % 4) +: 16] = rwsp_pkg::FIELD_W'(vals[k]);
    end
    if (profile == 9) begin
      words[$urandom_range(0, 3)] = {$urandom, $urandom};
    end
    count_data = rwsp_pkg::WORD_W'($urandom_range(1, 16));
    if ($urandom_range(0, 9) == 0) begin
      count_data = rwsp_pkg::WORD_W'($urandom_range(0, 31));
    end
    if ($urandom_range(0, 2) == 0) begin
      count_data[rwsp_pkg::WORD_W-1:rwsp_pkg::CNT_W] =
        (rwsp_pkg::WORD_W - rwsp_pkg::CNT_W)'({$urandom, $urandom});
    end
  endfunction

  initial begin
    rwsp_pkg::ratio_words_t      words;
    logic [rwsp_pkg::WORD_W-1:0] count_data;
    int                          picks_done;
    int                          phase;
    int                          n_items;

    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.request = 1'b0;
    pick_ch.ready  = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: one server of ratio one, with an ignored request
    pending_reqs.push_back(1'b1);
    pending_reqs.push_back(1'b0);
    pending_reqs.push_back(1'b1);
    pending_reqs.push_back(1'b1);

    // all ratio fields zero, taken as one, sixteen servers
    configure('0, rwsp_pkg::WORD_W'(rwsp_pkg::MAX_SERVERS), 1'b0);
    push_requests(6);

    // every field at its maximum, count above the limit saturates
    configure('1, '1, 1'b1);
    push_requests(5);

    // unsorted tiny ratios: total runs out twice, rearm path
    words          = '0;
    words[0][15:0] = 16'd1;
    words[0][31:16] = 16'd2;
    words[0][47:32] = 16'd1;
    configure(words, rwsp_pkg::WORD_W'(3), 1'b0);
    for (int i = 0; i < 8; i++) begin
      pending_reqs.push_back(1'b1);
    end

    // writes to unmapped indexes leave the state alone
    wait_idle();
    write_reg(REG_SPARE_5, {$urandom, $urandom});
    write_reg(REG_SPARE_7, '1);
    cfg_ch.valid <= 1'b0;
    pending_reqs.push_back(1'b1);
    pending_reqs.push_back(1'b1);

    // server count zero, taken as one
    words = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    configure(words, '0, 1'b1);
    pending_reqs.push_back(1'b1);
    pending_reqs.push_back(1'b1);

    picks_done = 0;
    phase      = 0;
    while (picks_done < RANDOM_PICKS) begin
      make_random_config(words, count_data);
      configure(words, count_data, 1'($urandom_range(0, 1)));
      if (RANDOM_PICKS - picks_done < 150) begin
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
      end else begin
        src_idle_pct <= (phase % 4 == 1) ? 0 : $urandom_range(5, 30);
        snk_idle_pct <= (phase % 4 == 2) ? 0 : $urandom_range(5, 30);
      end
      if (phase == 3) begin
        // stall the sink long enough to back up the request side
        long_hold_go <= 1'b1;
      end
      n_items = $urandom_range(10, 60);
      push_requests(n_items);
      picks_done += n_items;
      phase++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
